>>> hdl/sphere_broadphase_collision_scan_unit_defines.svh
// Assertion macros used by the checker file of the collision scan unit.
`ifndef SPHERE_BROADPHASE_COLLISION_SCAN_UNIT_DEFINES_SVH
`define SPHERE_BROADPHASE_COLLISION_SCAN_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is applied.
`define SBCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, quiet while reset is applied.
`define SBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/sbcs_pkg.sv
// Package of the collision scan unit: sizes and the buses between top level and cells.
package sbcs_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int COORD_BITS  = 20;
    localparam int IDX_W       = 5;
    localparam int RANGE_W     = 6;
    localparam int RAD_W       = 19;
    localparam int WORD_W      = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 2);

    // Broadcast write data for one table entry.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [RAD_W-1:0]             radius;
        logic [WORD_W-1:0]            group_bits;
        logic [WORD_W-1:0]            mask_bits;
        logic                         dying;
    } wr_t;

    // Query descriptor handed from cell to cell; idx is the slot of the receiving cell.
    typedef struct packed {
        logic                         valid;
        logic                         active;
        logic [IDX_W-1:0]             slot;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [RAD_W-1:0]             radius;
        logic [WORD_W-1:0]            group_bits;
        logic [WORD_W-1:0]            mask_bits;
        logic [RANGE_W-1:0]           start;
        logic [RANGE_W-1:0]           stop;
        logic [RANGE_W-1:0]           idx;
    } query_t;

endpackage

>>> hdl/sbcs_cell.sv
// One table entry with its two-stage sphere overlap test.
module sbcs_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  sbcs_pkg::wr_t  wr,
    input  logic           wr_sel,
    input  sbcs_pkg::query_t q_in,
    output sbcs_pkg::query_t q_out,
    output logic           hit
);

    localparam int D_W    = sbcs_pkg::COORD_BITS + 1;
    localparam int SQ_W   = 2 * sbcs_pkg::COORD_BITS + 1;
    localparam int SUM_W  = SQ_W + 2;
    localparam int RS_W   = sbcs_pkg::RAD_W + 1;
    localparam int RS2_W  = 2 * RS_W;
    localparam int CMP_W  = (SUM_W > RS2_W) ? SUM_W : RS2_W;

    logic signed [sbcs_pkg::COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic [sbcs_pkg::RAD_W-1:0]  rad_reg;
    logic [sbcs_pkg::WORD_W-1:0] grp_reg, msk_reg;
    logic                        dying_reg;

    sbcs_pkg::query_t q_reg, q_next;
    logic             s1_valid_reg;
    logic             ok_reg, ok_next;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg, sqx_next, sqy_next, sqz_next;
    logic [RS2_W-1:0] rs2_reg, rs2_next;
    logic             hit_reg, hit_next;

    logic signed [D_W-1:0]   dx, dy, dz;
    logic signed [2*D_W-1:0] px, py, pz;
    logic [RS_W-1:0]         rs;
    logic [SUM_W-1:0]        dsum;

    assign dx = $signed({q_in.x[sbcs_pkg::COORD_BITS-1], q_in.x})
              - $signed({x_reg[sbcs_pkg::COORD_BITS-1], x_reg});
    assign dy = $signed({q_in.y[sbcs_pkg::COORD_BITS-1], q_in.y})
              - $signed({y_reg[sbcs_pkg::COORD_BITS-1], y_reg});
    assign dz = $signed({q_in.z[sbcs_pkg::COORD_BITS-1], q_in.z})
              - $signed({z_reg[sbcs_pkg::COORD_BITS-1], z_reg});
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;
    assign sqx_next = px[SQ_W-1:0];
    assign sqy_next = py[SQ_W-1:0];
    assign sqz_next = pz[SQ_W-1:0];
    assign rs       = {1'b0, q_in.radius} + {1'b0, rad_reg};
    assign rs2_next = rs * rs;

    always_comb
    begin
        ok_next = q_in.active
               && (q_in.idx >= q_in.start) && (q_in.idx < q_in.stop)
               && (((q_in.group_bits & msk_reg) != '0) || ((grp_reg & q_in.mask_bits) != '0))
               && (rad_reg != '0) && !dying_reg
               && (q_in.idx != {1'b0, q_in.slot});
        q_next     = q_in;
        q_next.idx = q_in.idx + 1'b1;
    end

    assign dsum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    assign hit_next = ok_reg && (CMP_W'(dsum) < CMP_W'(rs2_reg));

    // Entry contents: radius, words and flag clear at reset so an unwritten slot never hits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg      <= '0;
            grp_reg      <= '0;
            msk_reg      <= '0;
            dying_reg    <= 1'b0;
            q_reg        <= '0;
            s1_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (wr_sel)
            begin
                rad_reg   <= wr.radius;
                grp_reg   <= wr.group_bits;
                msk_reg   <= wr.mask_bits;
                dying_reg <= wr.dying;
            end
            q_reg        <= q_next;
            s1_valid_reg <= q_in.valid;
            if (s1_valid_reg)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            x_reg <= wr.x;
            y_reg <= wr.y;
            z_reg <= wr.z;
        end
        if (q_in.valid)
        begin
            ok_reg  <= ok_next;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sqz_reg <= sqz_next;
            rs2_reg <= rs2_next;
        end
    end

    assign q_out = q_reg;
    assign hit   = hit_reg;

endmodule

>>> hdl/sphere_broadphase_collision_scan_unit.sv
// Top level of the sphere broad-phase collision scan unit.
//
//   Channel  Direction  Handshake            Beat contents
//   input    in         in_valid / in_stall  req_type, entry_index, position, radius,
//                                            group_bits, mask_bits, dying, start/end_index
//   output   out        out_valid/out_stall  hit_index, hit_valid, last
//
// A write beat leaves the unit idle, so in_stall stays low.
// A query beat walks the chain of TABLE_DEPTH cells one cell per cycle; each cell
// registers the squared distances and the radius sum for its test, then its hit flag.
// The hits then leave one per cycle while the output is not stalled, followed by the
// terminator. in_stall is high from a query beat until its terminator is in the output
// register. Reset clears the radius, group, mask and dying words of every entry at once.
// A stall on the output holds the output register and the drain of pending hits;
// the scan itself never waits.
module sphere_broadphase_collision_scan_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic [sbcs_pkg::IDX_W-1:0]            entry_index,
    input  logic signed [sbcs_pkg::COORD_BITS-1:0] pos_x,
    input  logic signed [sbcs_pkg::COORD_BITS-1:0] pos_y,
    input  logic signed [sbcs_pkg::COORD_BITS-1:0] pos_z,
    input  logic [sbcs_pkg::RAD_W-1:0]            radius,
    input  logic [sbcs_pkg::WORD_W-1:0]           group_bits,
    input  logic [sbcs_pkg::WORD_W-1:0]           mask_bits,
    input  logic                                  dying,
    input  logic [sbcs_pkg::RANGE_W-1:0]          start_index,
    input  logic [sbcs_pkg::RANGE_W-1:0]          end_index,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sbcs_pkg::IDX_W-1:0]            hit_index,
    output logic                                  hit_valid,
    output logic                                  last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    localparam logic [sbcs_pkg::CNT_W-1:0] SCAN_DONE = sbcs_pkg::CNT_W'(sbcs_pkg::TABLE_DEPTH + 1);
    localparam logic [sbcs_pkg::RANGE_W-1:0] DEPTH_R = sbcs_pkg::RANGE_W'(sbcs_pkg::TABLE_DEPTH);

    state_t                            state_reg;
    logic [sbcs_pkg::CNT_W-1:0]        cnt_reg;
    logic [sbcs_pkg::TABLE_DEPTH-1:0]  pend_reg;
    sbcs_pkg::query_t                  q_reg, q_next;
    logic                              out_valid_reg;
    logic [sbcs_pkg::IDX_W-1:0]        hit_index_reg;
    logic                              hit_valid_reg;
    logic                              last_reg;

    sbcs_pkg::wr_t                     wr;
    logic [sbcs_pkg::TABLE_DEPTH-1:0]  wr_sel;
    logic [sbcs_pkg::TABLE_DEPTH-1:0]  hits;
    sbcs_pkg::query_t                  chain [sbcs_pkg::TABLE_DEPTH+1];

    logic accept;
    logic out_load;

    // Lowest set bit of the pending hit vector.
    function automatic logic [sbcs_pkg::IDX_W-1:0] first_set(
        input logic [sbcs_pkg::TABLE_DEPTH-1:0] v
    );
        logic [sbcs_pkg::IDX_W-1:0] r;
        r = '0;
        for (int i = sbcs_pkg::TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = sbcs_pkg::IDX_W'(i);
            end
        end
        return r;
    endfunction

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_load = !out_valid_reg || !out_stall;

    // Write data goes to every cell; only the addressed one takes it.
    assign wr.x          = pos_x;
    assign wr.y          = pos_y;
    assign wr.z          = pos_z;
    assign wr.radius     = radius;
    assign wr.group_bits = group_bits;
    assign wr.mask_bits  = mask_bits;
    assign wr.dying      = dying;

    always_comb
    begin
        for (int i = 0; i < sbcs_pkg::TABLE_DEPTH; i++)
        begin
            wr_sel[i] = accept && !req_type
                     && ({1'b0, entry_index} == sbcs_pkg::RANGE_W'(i));
        end
    end

    // Query descriptor for the head of the chain. An empty query still walks the
    // chain, but with its active flag low no cell reports a hit.
    always_comb
    begin
        q_next            = '0;
        q_next.valid      = accept && req_type;
        q_next.active     = ((group_bits | mask_bits) != '0) && (radius != '0) && !dying;
        q_next.slot       = entry_index;
        q_next.x          = pos_x;
        q_next.y          = pos_y;
        q_next.z          = pos_z;
        q_next.radius     = radius;
        q_next.group_bits = group_bits;
        q_next.mask_bits  = mask_bits;
        q_next.start      = start_index;
        q_next.stop       = (end_index > DEPTH_R) ? DEPTH_R : end_index;
        q_next.idx        = '0;
    end

    assign chain[0] = q_reg;

    for (genvar g = 0; g < sbcs_pkg::TABLE_DEPTH; g++)
    begin : g_cell
        sbcs_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .wr     (wr),
            .wr_sel (wr_sel[g]),
            .q_in   (chain[g]),
            .q_out  (chain[g+1]),
            .hit    (hits[g])
        );
    end

    // Sequencer: waits for the scan to reach the last cell, then drains the hit
    // vector lowest slot first and closes with the terminator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= '0;
            q_reg         <= '0;
            out_valid_reg <= 1'b0;
            hit_index_reg <= '0;
            hit_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            q_reg <= q_next;
            // Outside the emit state a taken beat simply leaves the output register.
            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && req_type)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SCAN_DONE)
                    begin
                        pend_reg  <= hits;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        if (pend_reg != '0)
                        begin
                            hit_index_reg <= first_set(pend_reg);
                            hit_valid_reg <= 1'b1;
                            last_reg      <= 1'b0;
                            pend_reg      <= pend_reg & (pend_reg - 1'b1);
                        end
                        else
                        begin
                            hit_index_reg <= '0;
                            hit_valid_reg <= 1'b0;
                            last_reg      <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_index = hit_index_reg;
    assign hit_valid = hit_valid_reg;
    assign last      = last_reg;

endmodule

>>> hdl/sbcs_checker.sv
// Port-level checker for the collision scan unit and its bind statement.
`include "sphere_broadphase_collision_scan_unit_defines.svh"

module sbcs_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic                                   req_type,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic [sbcs_pkg::IDX_W-1:0]             hit_index,
    input logic                                   hit_valid,
    input logic                                   last
);

    // A stalled output beat holds its contents.
    `SBCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({hit_index, hit_valid, last}))

    // Every beat is either a hit or the terminator, never both.
    `SBCS_ASSERT_NOW(a_last_xor_hit, clk, rst_n, out_valid, last != hit_valid)

    // The terminator carries slot zero.
    `SBCS_ASSERT_NOW(a_term_index, clk, rst_n, out_valid && last, hit_index == '0)

    // A query beat keeps the unit busy for at least the following cycle.
    `SBCS_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && !in_stall && req_type, in_stall)

endmodule

bind sphere_broadphase_collision_scan_unit sbcs_checker u_sbcs_checker (.*);
